>>> rtl/core/indexed_list_store_defines.svh
// ---------------------------------------------------------------------------
// indexed_list_store_defines
// Assertion macros shared by the list store RTL.
// ---------------------------------------------------------------------------
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

// An invariant that holds on every clock edge out of reset.
`define ILS_ASSERT_ALWAYS(label, expr, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (expr)) else $error(msg);

// When the antecedent holds, the consequent holds in the same cycle.
`define ILS_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// When the antecedent holds, the consequent holds in the next cycle.
`define ILS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> rtl/core/ils_pkg.sv
// ---------------------------------------------------------------------------
// ils_pkg
// Codes, sequencer states and control/status bundles of the list store.
// ---------------------------------------------------------------------------
package ils_pkg;

    localparam logic [2:0] ACT_GET    = 3'd0;
    localparam logic [2:0] ACT_HEAD   = 3'd1;
    localparam logic [2:0] ACT_TAIL   = 3'd2;
    localparam logic [2:0] ACT_BEFORE = 3'd3;
    localparam logic [2:0] ACT_DELETE = 3'd4;

    localparam logic [1:0] STAT_DONE    = 2'd0;
    localparam logic [1:0] STAT_INVALID = 2'd1;
    localparam logic [1:0] STAT_FULL    = 2'd2;

    localparam int unsigned ACTION_W = 3;
    localparam int unsigned POS_W    = 8;
    localparam int unsigned VALUE_W  = 32;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned LENGTH_W = 7;
    localparam int unsigned S_TDATA_W = 48;
    localparam int unsigned M_TDATA_W = 48;

    // What a request turns into once it has been checked against the count.
    typedef enum logic [1:0] {
        K_NONE,
        K_GET,
        K_INS,
        K_DEL
    } kind_t;

    typedef enum logic [2:0] {
        S_IDLE,
        S_GET_RD,
        S_SHIFT,
        S_DRAIN,
        S_PUT,
        S_FIN
    } state_t;

    typedef struct packed {
        logic take;
        logic rd_en;
        logic shift_step;
        logic cnt_dec;
        logic put;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        kind_t new_kind;
        logic  new_move;
        kind_t cur_kind;
        logic  shift_last;
        logic  out_free;
    } sts_t;

endpackage

>>> rtl/core/ils_ctrl.sv
// ---------------------------------------------------------------------------
// ils_ctrl
// Sequencer for the list store: runs a get, a shift-and-put insert, a
// shift-down delete or no step (rejected), then hands the result to the output register.
// ---------------------------------------------------------------------------
module ils_ctrl (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          in_ready,
    input  ils_pkg::sts_t sts,
    output ils_pkg::cmd_t cmd
);

    ils_pkg::state_t state_reg;
    ils_pkg::state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ils_pkg::S_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ils_pkg::S_IDLE: begin
                if (s_tvalid) begin
                    case (sts.new_kind)
                        ils_pkg::K_GET: state_next = ils_pkg::S_GET_RD;
                        ils_pkg::K_INS: state_next = sts.new_move ? ils_pkg::S_SHIFT
                                                                  : ils_pkg::S_PUT;
                        ils_pkg::K_DEL: state_next = sts.new_move ? ils_pkg::S_SHIFT
                                                                  : ils_pkg::S_DRAIN;
                        default:        state_next = ils_pkg::S_FIN;
                    endcase
                end
            end
            ils_pkg::S_GET_RD: state_next = ils_pkg::S_FIN;
            ils_pkg::S_SHIFT: begin
                if (sts.shift_last) begin
                    state_next = ils_pkg::S_DRAIN;
                end
            end
            ils_pkg::S_DRAIN: begin
                state_next = (sts.cur_kind == ils_pkg::K_INS) ? ils_pkg::S_PUT
                                                              : ils_pkg::S_FIN;
            end
            ils_pkg::S_PUT: state_next = ils_pkg::S_FIN;
            ils_pkg::S_FIN: begin
                if (sts.out_free) begin
                    state_next = ils_pkg::S_IDLE;
                end
            end
            default: state_next = ils_pkg::S_IDLE;
        endcase
    end

    // No beat is taken while reset is held.
    always_comb begin
        cmd      = '0;
        in_ready = 1'b0;
        case (state_reg)
            ils_pkg::S_IDLE: begin
                in_ready = aresetn;
                cmd.take = s_tvalid && aresetn;
            end
            ils_pkg::S_GET_RD: cmd.rd_en = 1'b1;
            ils_pkg::S_SHIFT: begin
                cmd.rd_en      = 1'b1;
                cmd.shift_step = 1'b1;
            end
            ils_pkg::S_DRAIN: cmd.cnt_dec = (sts.cur_kind == ils_pkg::K_DEL);
            ils_pkg::S_PUT:   cmd.put = 1'b1;
            ils_pkg::S_FIN:   cmd.load_out = sts.out_free;
            default: begin
                cmd      = '0;
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

>>> rtl/core/ils_dp.sv
// ---------------------------------------------------------------------------
// ils_dp
// Datapath of the list store: request check, slot memory with a one-entry
// move pipeline, fill count and the result register.
// ---------------------------------------------------------------------------
`include "indexed_list_store_defines.svh"

module ils_dp #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic [ils_pkg::ACTION_W-1:0]        in_action,
    input  logic signed [ils_pkg::POS_W-1:0]    in_position,
    input  logic signed [ils_pkg::VALUE_W-1:0]  in_write_value,
    input  ils_pkg::cmd_t                       cmd,
    output ils_pkg::sts_t                       sts,
    input  logic                                m_tready,
    output logic                                out_valid,
    output logic signed [ils_pkg::VALUE_W-1:0]  out_read_value,
    output logic [ils_pkg::STATUS_W-1:0]        out_status,
    output logic [ils_pkg::LENGTH_W-1:0]        out_length
);

    localparam int unsigned AW   = $clog2(CAPACITY);
    localparam int unsigned CW   = $clog2(CAPACITY + 1);
    localparam int unsigned CMPW = (CW > ils_pkg::POS_W) ? CW : ils_pkg::POS_W;

    logic signed [ils_pkg::VALUE_W-1:0] mem [CAPACITY];

    logic [CW-1:0]                      count_reg;
    ils_pkg::kind_t                     kind_reg;
    logic [ils_pkg::STATUS_W-1:0]       status_reg;
    logic signed [ils_pkg::VALUE_W-1:0] val_reg;
    logic [AW-1:0]                      at_reg;
    logic [AW-1:0]                      idx_reg;
    logic [AW-1:0]                      end_reg;
    logic signed [ils_pkg::VALUE_W-1:0] rd_data_reg;
    logic                               mov_valid_reg;
    logic [AW-1:0]                      mov_addr_reg;
    logic                               out_valid_reg;
    logic signed [ils_pkg::VALUE_W-1:0] out_value_reg;
    logic [ils_pkg::STATUS_W-1:0]       out_status_reg;
    logic [ils_pkg::LENGTH_W-1:0]       out_length_reg;

    // Request check against the current count.
    logic                         pos_neg;
    logic [CMPW-1:0]              pos_u;
    logic [CMPW-1:0]              cnt_x;
    logic                         in_range;
    logic                         is_full;
    logic [AW-1:0]                ins_at;
    ils_pkg::kind_t               new_kind;
    logic [ils_pkg::STATUS_W-1:0] new_status;
    logic                         new_move;

    always_comb begin
        pos_neg    = in_position[ils_pkg::POS_W-1];
        pos_u      = CMPW'($unsigned(in_position));
        cnt_x      = CMPW'(count_reg);
        in_range   = !pos_neg && (pos_u < cnt_x);
        is_full    = (count_reg == CW'(CAPACITY));
        ins_at     = '0;
        new_kind   = ils_pkg::K_NONE;
        new_status = ils_pkg::STAT_INVALID;
        new_move   = 1'b0;
        case (in_action)
            ils_pkg::ACT_GET: begin
                if (in_range) begin
                    new_kind   = ils_pkg::K_GET;
                    new_status = ils_pkg::STAT_DONE;
                end
            end
            ils_pkg::ACT_HEAD, ils_pkg::ACT_TAIL, ils_pkg::ACT_BEFORE: begin
                if (in_action == ils_pkg::ACT_TAIL) begin
                    ins_at = AW'(count_reg);
                end else if (in_action == ils_pkg::ACT_BEFORE && !pos_neg) begin
                    ins_at = pos_u[AW-1:0];
                end
                // Insert before a position past the end is rejected before the full check.
                if (in_action == ils_pkg::ACT_BEFORE && !pos_neg && pos_u > cnt_x) begin
                    new_status = ils_pkg::STAT_INVALID;
                end else if (is_full) begin
                    new_status = ils_pkg::STAT_FULL;
                end else begin
                    new_kind   = ils_pkg::K_INS;
                    new_status = ils_pkg::STAT_DONE;
                    new_move   = (CW'(ins_at) != count_reg);
                end
            end
            ils_pkg::ACT_DELETE: begin
                if (in_range) begin
                    new_kind   = ils_pkg::K_DEL;
                    new_status = ils_pkg::STAT_DONE;
                    new_move   = ((pos_u + 1'b1) != cnt_x);
                end
            end
            default: begin
                new_kind   = ils_pkg::K_NONE;
                new_status = ils_pkg::STAT_INVALID;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (cmd.take) begin
            kind_reg   <= new_kind;
            status_reg <= new_status;
            val_reg    <= in_write_value;
            at_reg     <= ins_at;
            if (new_kind == ils_pkg::K_INS) begin
                idx_reg <= AW'(count_reg - 1'b1);
                end_reg <= ins_at;
            end else if (new_kind == ils_pkg::K_DEL) begin
                idx_reg <= AW'(pos_u + 1'b1);
                end_reg <= AW'(count_reg - 1'b1);
            end else begin
                idx_reg <= pos_u[AW-1:0];
                end_reg <= pos_u[AW-1:0];
            end
        end else if (cmd.shift_step) begin
            idx_reg <= (kind_reg == ils_pkg::K_INS) ? AW'(idx_reg - 1'b1)
                                                    : AW'(idx_reg + 1'b1);
        end
    end

    // Each beat of a shift reads one slot; the next cycle writes it one place over.
    always_ff @(posedge aclk) begin
        if (cmd.rd_en) begin
            rd_data_reg <= mem[idx_reg];
        end
        if (mov_valid_reg) begin
            mem[mov_addr_reg] <= rd_data_reg;
        end else if (cmd.put) begin
            mem[at_reg] <= val_reg;
        end
    end

    always_ff @(posedge aclk) begin
        mov_addr_reg <= (kind_reg == ils_pkg::K_INS) ? AW'(idx_reg + 1'b1)
                                                     : AW'(idx_reg - 1'b1);
        if (!aresetn) begin
            mov_valid_reg <= 1'b0;
        end else begin
            mov_valid_reg <= cmd.shift_step;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else if (cmd.put) begin
            count_reg <= CW'(count_reg + 1'b1);
        end else if (cmd.cnt_dec) begin
            count_reg <= CW'(count_reg - 1'b1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.load_out) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_value_reg  <= (kind_reg == ils_pkg::K_GET) ? rd_data_reg : '1;
            out_status_reg <= status_reg;
            out_length_reg <= ils_pkg::LENGTH_W'(count_reg);
        end
    end

    assign sts.new_kind   = new_kind;
    assign sts.new_move   = new_move;
    assign sts.cur_kind   = kind_reg;
    assign sts.shift_last = (idx_reg == end_reg);
    assign sts.out_free   = !out_valid_reg || m_tready;

    assign out_valid      = out_valid_reg;
    assign out_read_value = out_value_reg;
    assign out_status     = out_status_reg;
    assign out_length     = out_length_reg;

    `ILS_ASSERT_ALWAYS(a_count_bound, count_reg <= CW'(CAPACITY), "count above capacity")
    `ILS_ASSERT_IMPL(a_put_no_move, cmd.put, !mov_valid_reg, "put collides with a move")
    `ILS_ASSERT_IMPL(a_load_free, cmd.load_out, !out_valid_reg || m_tready,
                     "result loaded over a pending beat")
    `ILS_ASSERT_NEXT(a_put_count, cmd.put, count_reg == CW'($past(count_reg) + 1'b1),
                     "insert did not grow the count")

endmodule

>>> rtl/core/indexed_list_store.sv
// ---------------------------------------------------------------------------
// indexed_list_store: ordered store of up to CAPACITY signed 32-bit values.
// One item at a time; the slot memory port moves one entry per cycle.
// Synchronous active-low reset clears the count; slots are not cleared.
// ---------------------------------------------------------------------------
module indexed_list_store #(
    parameter int unsigned CAPACITY = 64
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // action [2:0], position [10:3], write_value [42:11], zeros above
    input  logic [ils_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // read_value [31:0], status [33:32], length [40:34], zeros above
    output logic [ils_pkg::M_TDATA_W-1:0]     m_tdata
);

    ils_pkg::cmd_t cmd;
    ils_pkg::sts_t sts;

    logic signed [ils_pkg::VALUE_W-1:0] out_read_value;
    logic [ils_pkg::STATUS_W-1:0]       out_status;
    logic [ils_pkg::LENGTH_W-1:0]       out_length;

    ils_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .in_ready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    ils_dp #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .in_action      (s_tdata[2:0]),
        .in_position    (s_tdata[10:3]),
        .in_write_value (s_tdata[42:11]),
        .cmd            (cmd),
        .sts            (sts),
        .m_tready       (m_tready),
        .out_valid      (m_tvalid),
        .out_read_value (out_read_value),
        .out_status     (out_status),
        .out_length     (out_length)
    );

    assign m_tdata = {7'd0, out_length, out_status, out_read_value};

endmodule
